FILE: sv/spidx_pkg.sv
// shared types and constants of the stepper position indexer
`default_nettype none

package spidx_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;
    localparam int unsigned INTERVAL_BITS     = 16;
    localparam int unsigned TARGET_BITS       = 16;
    localparam int unsigned WINDING_COUNT     = 4;
    localparam int unsigned PHASE_BITS        = 2;
    localparam int unsigned POS_OUT_BITS      = 16;
    localparam int unsigned ADDR_BITS         = 3;
    localparam int unsigned DATA_BITS         = 32;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd10;
    localparam logic [INTERVAL_BITS-1:0] ELAPSED_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_STOP  = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_STEP_INTERVAL = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic                     rejected;
        logic                     arrived;
        logic                     busy_res;
        logic [POS_OUT_BITS-1:0]  position;
        logic [WINDING_COUNT-1:0] winding;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/spidx_cfg.sv
// configuration register block behind the apb-style port
`default_nettype none

module spidx_cfg (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [spidx_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [spidx_pkg::DATA_BITS-1:0]        pwdata,
    output logic      [spidx_pkg::DATA_BITS-1:0]        prdata,
    output logic                                        pready,
    output logic      [spidx_pkg::INTERVAL_BITS-1:0]    step_interval
);

    logic [spidx_pkg::INTERVAL_BITS-1:0] interval_reg;
    logic [spidx_pkg::INTERVAL_BITS-1:0] interval_next;
    logic                                 sel_interval;

    assign pready       = 1'b1;
    assign sel_interval = (paddr[2] == spidx_pkg::REG_STEP_INTERVAL) && (paddr[1:0] == 2'd0);

    always_comb begin
        interval_next = interval_reg;
        if (psel && penable && pwrite && pready && sel_interval) begin
            interval_next = pwdata[spidx_pkg::INTERVAL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= spidx_pkg::INTERVAL_RESET;
        end else begin
            interval_reg <= interval_next;
        end
    end

    assign prdata        = sel_interval ? spidx_pkg::DATA_BITS'(interval_reg) : '0;
    assign step_interval = interval_reg;

endmodule

`default_nettype wire

FILE: sv/spidx_core.sv
// motion state and single-pass update for one request
`default_nettype none

module spidx_core #(
    parameter int unsigned POSITION_BITS = spidx_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire logic [1:0]                          operation,
    input  wire logic [spidx_pkg::TARGET_BITS-1:0]   target_step,
    input  wire logic [spidx_pkg::INTERVAL_BITS-1:0] step_interval,
    output spidx_pkg::result_t                       result
);

    logic [POSITION_BITS-1:0]                pos_reg,     pos_next;
    logic [POSITION_BITS-1:0]                dest_reg,    dest_next;
    logic                                    moving_reg,  moving_next;
    logic [spidx_pkg::PHASE_BITS-1:0]        phase_reg,   phase_next;
    logic                                    coil_reg,    coil_next;
    logic [spidx_pkg::INTERVAL_BITS-1:0]     elapsed_reg, elapsed_next;

    logic [spidx_pkg::INTERVAL_BITS-1:0]     need;
    logic [spidx_pkg::INTERVAL_BITS-1:0]     elapsed_inc;
    logic [31:0]                             target_wide;
    logic [31:0]                             pos_wide;
    logic                                    arrived;
    logic                                    rejected;
    spidx_pkg::op_t                          op;

    assign op          = spidx_pkg::op_t'(operation);
    assign need        = (step_interval == '0) ? spidx_pkg::INTERVAL_BITS'(1) : step_interval;
    assign elapsed_inc = (elapsed_reg == spidx_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                 : elapsed_reg + 1'b1;
    assign target_wide = 32'($signed(target_step));

    always_comb begin
        pos_next     = pos_reg;
        dest_next    = dest_reg;
        moving_next  = moving_reg;
        phase_next   = phase_reg;
        coil_next    = coil_reg;
        elapsed_next = elapsed_reg;
        arrived      = 1'b0;
        rejected     = 1'b0;
        unique case (op)
            spidx_pkg::OP_TICK: begin
                elapsed_next = elapsed_inc;
                if (moving_reg && (elapsed_inc >= need)) begin
                    coil_next = 1'b0;
                    if (pos_reg == dest_reg) begin
                        moving_next = 1'b0;
                        arrived     = 1'b1;
                    end else begin
                        if ($signed(dest_reg) < $signed(pos_reg)) begin
                            pos_next   = pos_reg - 1'b1;
                            phase_next = phase_reg - 1'b1;
                        end else begin
                            pos_next   = pos_reg + 1'b1;
                            phase_next = phase_reg + 1'b1;
                        end
                        coil_next    = 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            spidx_pkg::OP_MOVE: begin
                if (moving_reg) begin
                    rejected = 1'b1;
                end else begin
                    dest_next    = target_wide[POSITION_BITS-1:0];
                    moving_next  = 1'b1;
                    elapsed_next = '0;
                end
            end
            spidx_pkg::OP_STOP: begin
                if (moving_reg) begin
                    coil_next   = 1'b0;
                    dest_next   = pos_reg;
                    moving_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            dest_reg    <= '0;
            moving_reg  <= 1'b0;
            phase_reg   <= '0;
            coil_reg    <= 1'b0;
            elapsed_reg <= '0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            dest_reg    <= dest_next;
            moving_reg  <= moving_next;
            phase_reg   <= phase_next;
            coil_reg    <= coil_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign pos_wide = 32'(pos_next);

    always_comb begin
        result.winding  = coil_next ? (spidx_pkg::WINDING_COUNT'(1) << phase_next) : '0;
        result.position = pos_wide[spidx_pkg::POS_OUT_BITS-1:0];
        result.busy_res = moving_next;
        result.arrived  = arrived;
        result.rejected = rejected;
    end

endmodule

`default_nettype wire

FILE: sv/spidx_out.sv
// result register towards the master side
`default_nettype none

module spidx_out (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire spidx_pkg::result_t result,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic             ready_in,
    output logic [23:0]      m_tdata
);

    logic               valid_reg, valid_next;
    spidx_pkg::result_t data_reg;

    assign ready_in = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = 24'(data_reg);

endmodule

`default_nettype wire

FILE: sv/stepper_position_indexer_unit.sv
// top level of the four-winding wave-drive stepper indexer
//
// requests enter on the s_ stream: s_tuser carries the operation (tick, move,
// emergency stop or spare no-op), s_tdata the signed 16-bit target step of a move.
// every request gives exactly one result on the m_ stream: winding drive,
// low 16 bits of the position, busy flag, arrival pulse and rejection flag.
// the result is loaded into the output register at the edge that takes the
// request and waits there until the receiver takes it.
// throughput is one request per cycle while the receiver keeps m_tready high.
// the output register decouples the sides: a new request is taken while the
// register is empty or is being drained in the same cycle; while the receiver
// holds m_tready low the result stays put and s_tready drops.
// the step interval (reset 10 ticks) sits at byte address 0 of the apb port
// and the user writes it only while the block is idle; nothing enforces it.
// reset clears position, destination, phase, windings, tick counter and the
// output register; the block takes requests in the first cycle after reset.
`default_nettype none

module stepper_position_indexer_unit #(
    parameter int unsigned POSITION_BITS = spidx_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,   // target_step
    input  wire logic [1:0]                          s_tuser,   // operation
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // winding[3:0], position[19:4], busy_res[20], arrived[21], rejected[22], zero
    output logic [23:0]                              m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [spidx_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [spidx_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [spidx_pkg::DATA_BITS-1:0]     prdata,
    output logic                                     pready
);

    logic [spidx_pkg::INTERVAL_BITS-1:0] step_interval;
    logic                                accept;
    spidx_pkg::result_t                  result;

    assign accept = s_tvalid && s_tready;

    spidx_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .step_interval (step_interval)
    );

    spidx_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .operation     (s_tuser),
        .target_step   (s_tdata),
        .step_interval (step_interval),
        .result        (result)
    );

    spidx_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .ready_in (s_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/stepper_position_indexer_unit_tb.sv
// self-checking testbench of the wave-drive stepper position indexer
`timescale 1ns / 1ps

module stepper_position_indexer_unit_tb;
    import spidx_pkg::*;

    localparam int unsigned POS_W      = POSITION_BITS_DEF;
    localparam int unsigned IDLE_LIMIT = 1000;

    class step_indexer_scoreboard;
        logic [15:0]      step_interval;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] destination;
        logic [1:0]       phase;
        logic [15:0]      elapsed;
        bit               moving;
        bit               coil_on;
        result_t          due_results[$];
        int               errors;

        function new();
            step_interval = INTERVAL_RESET;
            position      = '0;
            destination   = '0;
            phase         = '0;
            elapsed       = '0;
            moving        = 1'b0;
            coil_on       = 1'b0;
            errors        = 0;
        endfunction

        function void set_interval(logic [31:0] value);
            step_interval = value[15:0];
        endfunction

        function void take_request(op_t op, logic [15:0] target);
            result_t     r;
            logic [15:0] need;
            r    = '0;
            need = (step_interval == 16'd0) ? 16'd1 : step_interval;
            case (op)
                OP_TICK: begin
                    if (elapsed != ELAPSED_MAX)
                        elapsed = elapsed + 16'd1;
                    if (moving && elapsed >= need) begin
                        coil_on = 1'b0;
                        if (position == destination) begin
                            moving    = 1'b0;
                            r.arrived = 1'b1;
                        end else begin
                            if ($signed(destination) < $signed(position)) begin
                                position = position - 1'b1;
                                phase    = phase + 2'd3;
                            end else begin
                                position = position + 1'b1;
                                phase    = phase + 2'd1;
                            end
                            coil_on = 1'b1;
                            elapsed = '0;
                        end
                    end
                end
                OP_MOVE: begin
                    if (moving) begin
                        r.rejected = 1'b1;
                    end else begin
                        destination = POS_W'($signed(target));
                        moving      = 1'b1;
                        elapsed     = '0;
                    end
                end
                OP_STOP: begin
                    if (moving) begin
                        coil_on     = 1'b0;
                        destination = position;
                        moving      = 1'b0;
                    end
                end
                default: ;
            endcase
            r.winding  = coil_on ? (4'b0001 << phase) : 4'b0000;
            r.position = position[15:0];
            r.busy_res = moving;
            due_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 50)
                $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [23:0] data);
            result_t got;
            result_t want;
            got = data[22:0];
            if (data[23] !== 1'b0)
                report_mismatch("padding bit", 32'(data[23]), 32'd0);
            if (due_results.size() == 0) begin
                report_mismatch("unrequested result", 32'(data), 32'd0);
                return;
            end
            want = due_results.pop_front();
            if (got.winding !== want.winding)
                report_mismatch("winding", 32'(got.winding), 32'(want.winding));
            if (got.position !== want.position)
                report_mismatch("position", 32'(got.position), 32'(want.position));
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy", 32'(got.busy_res), 32'(want.busy_res));
            if (got.arrived !== want.arrived)
                report_mismatch("arrived", 32'(got.arrived), 32'(want.arrived));
            if (got.rejected !== want.rejected)
                report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // target_step
    logic [1:0]           s_tuser;   // operation
    logic                 m_tvalid;
    logic                 m_tready;
    // winding[3:0], position[19:4], busy_res[20], arrived[21], rejected[22], zero
    logic [23:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    step_indexer_scoreboard sb;
    bit                     quiet;
    bit                     tx_gaps;
    bit                     rx_gaps;
    int unsigned            idle_cycles;

    stepper_position_indexer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int unsigned draw_wait(bit gaps_on);
        if (quiet || !gaps_on)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic send_request(op_t op, logic [15:0] target);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            tx_gaps = !tx_gaps;
        gap = draw_wait(tx_gaps);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= target;
        do @(posedge aclk); while (!s_tready);
        sb.take_request(op, target);
    endtask

    task automatic set_step_interval(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(REG_STEP_INTERVAL) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_interval(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[15:0] !== value[15:0])
            sb.report_mismatch("step interval readback", 32'(prdata[15:0]), 32'(value[15:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // moves near the current position, ticks until arrival, occasional stops and noise
    task automatic run_motion_mix(int count);
        int unsigned roll;
        logic [15:0] target;
        for (int i = 0; i < count; i++) begin
            roll   = $urandom_range(0, 99);
            target = sb.position[15:0] + 16'($urandom_range(0, 12)) - 16'd6;
            if (!sb.moving) begin
                if (roll < 60)
                    send_request(OP_MOVE, target);
                else if (roll < 68)
                    send_request(OP_MOVE, 16'($urandom_range(0, 65535)));
                else if (roll < 84)
                    send_request(OP_TICK, 16'($urandom_range(0, 65535)));
                else if (roll < 90)
                    send_request(OP_STOP, 16'($urandom_range(0, 65535)));
                else if (roll < 95)
                    send_request(OP_SPARE, 16'($urandom_range(0, 65535)));
                else
                    send_request(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            end else begin
                if (roll < 86)
                    send_request(OP_TICK, 16'($urandom_range(0, 65535)));
                else if (roll < 91)
                    send_request(OP_MOVE, 16'($urandom_range(0, 65535)));
                else if (roll < 94)
                    send_request(OP_STOP, 16'($urandom_range(0, 65535)));
                else
                    send_request(OP_SPARE, 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    // longest interval: a burst of ticks stays well short of the next step
    task automatic run_longest_step();
        quiet = 1'b1;
        if (sb.moving)
            send_request(OP_STOP, 16'h0000);
        send_request(OP_MOVE, sb.position[15:0] ^ 16'h0001);
        repeat (40) send_request(OP_TICK, 16'h0000);
        send_request(OP_STOP, 16'h0000);
        quiet = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            int unsigned gap;
            if ($urandom_range(0, 39) == 0)
                rx_gaps = !rx_gaps;
            gap = draw_wait(rx_gaps);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb       = new();
        quiet    = 1'b0;
        tx_gaps  = 1'b1;
        rx_gaps  = 1'b1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset interval: spare code, idle stop, arrival without a step,
        // rejected move, one step downward toward the most negative target
        send_request(OP_SPARE, 16'hFFFF);
        send_request(OP_STOP, 16'h0000);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_MOVE, 16'h0000);
        repeat (10) send_request(OP_TICK, 16'h0000);
        send_request(OP_MOVE, 16'h8000);
        send_request(OP_MOVE, 16'h7FFF);
        repeat (10) send_request(OP_TICK, 16'hFFFF);
        send_request(OP_STOP, 16'h0000);

        set_step_interval(32'd1);
        run_motion_mix(150);
        set_step_interval(32'd3);
        run_motion_mix(120);
        set_step_interval(32'd0);
        run_motion_mix(120);
        set_step_interval(32'd65535);
        run_longest_step();
        set_step_interval(32'd2);
        run_motion_mix(150);
        set_step_interval({16'($urandom_range(1, 65535)), 16'd1});
        run_motion_mix(120);
        set_step_interval(32'd10);
        run_motion_mix(60);

        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
